[design/ncbp_pkg.sv]
// ----------------------------------------------------------------------------
// ncbp_pkg
// Shared types and constants of the node command byte parser.
// ----------------------------------------------------------------------------
package ncbp_pkg;

  // default number of note slots
  localparam int NOTE_DEPTH_DEF = 512;

  // fixed field widths
  localparam int BYTE_W  = 8;
  localparam int NODE_W  = 4;
  localparam int INDEX_W = 9;
  localparam int DUR_W   = 16;
  localparam int COUNT_W = 16;
  localparam int POS_W   = 17;
  localparam int SLOT_W  = 10;

  // command codes in the upper nibble of an idle byte
  localparam logic [3:0] CMD_LOAD   = 4'h1;
  localparam logic [3:0] CMD_START  = 4'h3;
  localparam logic [3:0] CMD_STOP   = 4'h4;
  localparam logic [3:0] CMD_ASTART = 4'h5;
  localparam logic [3:0] CMD_ASTOP  = 4'h6;
  localparam logic [3:0] CMD_SYNC   = 4'h8;

  // reply codes
  localparam logic [1:0] RC_OK   = 2'd0;
  localparam logic [1:0] RC_BAD  = 2'd1;
  localparam logic [1:0] RC_SIZE = 2'd2;

  // position within a note triple
  localparam logic [1:0] PH_NOTE = 2'd0;
  localparam logic [1:0] PH_DURH = 2'd1;
  localparam logic [1:0] PH_DURL = 2'd2;

  // one result item
  typedef struct packed {
    logic               reply_valid;
    logic [1:0]         reply_code;
    logic               entry_valid;
    logic [INDEX_W-1:0] entry_index;
    logic [BYTE_W-1:0]  entry_note;
    logic [DUR_W-1:0]   entry_duration;
    logic               playing;
    logic               restart_playback;
    logic               clear_sync_wait;
    logic               data_ready;
  } result_t;

endpackage

[design/ncbp_parser.sv]
// ----------------------------------------------------------------------------
// ncbp_parser
// Per-byte command and load parser: updates its state on each accepted byte
// and produces that byte's result.
// ----------------------------------------------------------------------------
module ncbp_parser #(
  parameter int NOTE_DEPTH = ncbp_pkg::NOTE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ncbp_pkg::NODE_W-1:0] cfg_node_id,
  input  logic                        byte_we,
  input  logic [ncbp_pkg::BYTE_W-1:0] rx_byte,
  output ncbp_pkg::result_t           result
);

  // a load is too large once count / 3 exceeds the slot count
  localparam logic [ncbp_pkg::POS_W-1:0] BIG_MIN = ncbp_pkg::POS_W'(3 * NOTE_DEPTH + 3);
  localparam logic [ncbp_pkg::SLOT_W:0]  SLOT_LIM = (ncbp_pkg::SLOT_W + 1)'(NOTE_DEPTH);

  logic [ncbp_pkg::NODE_W-1:0]  node_id_r;
  logic                         loading_r, loading_nxt;
  logic [ncbp_pkg::NODE_W-1:0]  target_r, target_nxt;
  logic                         chs_r, chs_nxt;
  logic                         cls_r, cls_nxt;
  logic [ncbp_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [ncbp_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic [ncbp_pkg::BYTE_W-1:0]  xor_r, xor_nxt;
  logic [ncbp_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [ncbp_pkg::BYTE_W-1:0]  note_r, note_nxt;
  logic [ncbp_pkg::BYTE_W-1:0]  durh_r, durh_nxt;
  logic                         playing_r, playing_nxt;
  logic                         ready_r, ready_nxt;

  logic [3:0]                   cmd;
  logic [ncbp_pkg::NODE_W-1:0]  tgt;
  logic [ncbp_pkg::POS_W-1:0]   count_ext;
  logic                         too_big;
  logic                         pos_inc;

  assign cmd       = rx_byte[7:4];
  assign tgt       = rx_byte[3:0];
  assign count_ext = {1'b0, count_r};
  assign too_big   = (count_ext >= BIG_MIN);

  // next state and result of one byte
  always_comb begin
    loading_nxt = loading_r;
    target_nxt  = target_r;
    chs_nxt     = chs_r;
    cls_nxt     = cls_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    xor_nxt     = xor_r;
    slot_nxt    = slot_r;
    note_nxt    = note_r;
    durh_nxt    = durh_r;
    playing_nxt = playing_r;
    ready_nxt   = ready_r;
    pos_inc     = 1'b0;
    result      = '0;

    if (!loading_r) begin
      case (cmd)
        ncbp_pkg::CMD_LOAD: begin
          loading_nxt = 1'b1;
          target_nxt  = tgt;
          chs_nxt     = 1'b0;
          cls_nxt     = 1'b0;
          pos_nxt     = '0;
          phase_nxt   = ncbp_pkg::PH_NOTE;
          slot_nxt    = '0;
          xor_nxt     = '0;
          ready_nxt   = 1'b0;
        end
        ncbp_pkg::CMD_START: begin
          result.restart_playback = 1'b1;
          playing_nxt             = 1'b1;
          result.clear_sync_wait  = 1'b1;
        end
        ncbp_pkg::CMD_STOP: begin
          playing_nxt            = 1'b0;
          result.clear_sync_wait = 1'b1;
        end
        ncbp_pkg::CMD_ASTART: begin
          if (tgt == node_id_r) begin
            result.restart_playback = 1'b1;
            playing_nxt             = 1'b1;
            result.clear_sync_wait  = 1'b1;
          end
        end
        ncbp_pkg::CMD_ASTOP: begin
          if (tgt == node_id_r) begin
            playing_nxt            = 1'b0;
            result.clear_sync_wait = 1'b1;
          end
        end
        ncbp_pkg::CMD_SYNC: begin
          result.clear_sync_wait = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (!chs_r) begin
      count_nxt = {rx_byte, 8'h00};
      chs_nxt   = 1'b1;
    end else if (!cls_r) begin
      count_nxt = count_r | {8'h00, rx_byte};
      cls_nxt   = 1'b1;
    end else if (target_r == node_id_r) begin
      if (too_big) begin
        pos_inc = 1'b1;
      end else if (pos_r < count_ext) begin
        // data byte of a note triple
        case (phase_r)
          ncbp_pkg::PH_NOTE: note_nxt = rx_byte;
          ncbp_pkg::PH_DURH: durh_nxt = rx_byte;
          default: begin
            if ({1'b0, slot_r} < SLOT_LIM) begin
              result.entry_valid    = 1'b1;
              result.entry_index    = slot_r[ncbp_pkg::INDEX_W-1:0];
              result.entry_note     = note_r;
              result.entry_duration = {durh_r, rx_byte};
              slot_nxt              = slot_r + 1'b1;
            end
          end
        endcase
        pos_inc = 1'b1;
        xor_nxt = xor_r ^ rx_byte;
      end else if (pos_r == count_ext) begin
        // check byte
        result.reply_valid = 1'b1;
        if (rx_byte == xor_r) begin
          result.reply_code = ncbp_pkg::RC_OK;
          ready_nxt         = 1'b1;
        end else begin
          result.reply_code = ncbp_pkg::RC_BAD;
          ready_nxt         = 1'b0;
        end
        pos_inc = 1'b1;
      end
    end else begin
      // load for another node: count and skip
      if (pos_r <= count_ext) pos_inc = 1'b1;
    end

    if (pos_inc) begin
      pos_nxt   = pos_r + 1'b1;
      phase_nxt = (phase_r == ncbp_pkg::PH_DURL) ? ncbp_pkg::PH_NOTE : phase_r + 1'b1;
    end

    // end of load once the check byte is consumed
    if (loading_r && chs_r && cls_r && (pos_nxt > count_ext)) begin
      loading_nxt = 1'b0;
      target_nxt  = '0;
      if ((target_r == node_id_r) && too_big) begin
        result.reply_valid = 1'b1;
        result.reply_code  = ncbp_pkg::RC_SIZE;
        ready_nxt          = 1'b0;
      end
    end

    result.playing    = playing_nxt;
    result.data_ready = ready_nxt;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= '0;
    end else if (cfg_we) begin
      node_id_r <= cfg_node_id;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r <= 1'b0;
      target_r  <= '0;
      chs_r     <= 1'b0;
      cls_r     <= 1'b0;
      count_r   <= '0;
      pos_r     <= '0;
      phase_r   <= ncbp_pkg::PH_NOTE;
      xor_r     <= '0;
      slot_r    <= '0;
      note_r    <= '0;
      durh_r    <= '0;
      playing_r <= 1'b0;
      ready_r   <= 1'b0;
    end else if (byte_we) begin
      loading_r <= loading_nxt;
      target_r  <= target_nxt;
      chs_r     <= chs_nxt;
      cls_r     <= cls_nxt;
      count_r   <= count_nxt;
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      xor_r     <= xor_nxt;
      slot_r    <= slot_nxt;
      note_r    <= note_nxt;
      durh_r    <= durh_nxt;
      playing_r <= playing_nxt;
      ready_r   <= ready_nxt;
    end
  end

  // phase tracks the position modulo three
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("triple phase out of range");

  // an idle parser holds no target
  a_idle_target: assert property (@(posedge clk) disable iff (!rst_n)
    !loading_r |-> (target_r == '0))
    else $error("target kept after load end");

  // a data byte of a load never runs past the stored count plus check byte
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loading_r |-> (pos_r <= count_ext))
    else $error("load position past count");

endmodule

[design/ncbp_out_buf.sv]
// ----------------------------------------------------------------------------
// ncbp_out_buf
// Two-entry result buffer: a result register with a skid entry behind it.
// ----------------------------------------------------------------------------
module ncbp_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ncbp_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output ncbp_pkg::result_t out_data
);

  logic              main_v_r;
  logic              skid_v_r;
  ncbp_pkg::result_t main_d_r;
  ncbp_pkg::result_t skid_d_r;
  logic              pop;

  assign pop       = main_v_r && out_ready;
  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v_r) begin
          skid_v_r <= 1'b0;
        end else begin
          main_v_r <= push;
        end
      end else if (push) begin
        if (main_v_r) begin
          skid_v_r <= 1'b1;
        end else begin
          main_v_r <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) begin
        main_d_r <= skid_d_r;
      end else if (push) begin
        main_d_r <= push_data;
      end
    end else if (push) begin
      if (main_v_r) begin
        skid_d_r <= push_data;
      end else begin
        main_d_r <= push_data;
      end
    end
  end

  // the skid entry is only used behind a full result register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry filled ahead of result register");

  // a waiting result is not dropped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (main_v_r && !out_ready) |=> (main_v_r && $stable(main_d_r)))
    else $error("stalled result changed");

  // a filled skid entry holds until it moves forward
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !pop) |=> (skid_v_r && $stable(skid_d_r)))
    else $error("skid entry lost");

endmodule

[design/node_command_byte_parser_top.sv]
// ----------------------------------------------------------------------------
// node_command_byte_parser_top
// Bus byte parser for one node: commands, note loads and replies.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and delivers exactly one result per
// byte from the result register of a two-entry output buffer; in_ready
// drops only while both buffer entries are full. The parser state updates
// in the accept cycle from short logic on the byte and the current state,
// so throughput is one byte per clock while in_ready is high. cfg_ready is
// always high; node_id should be written between requests.
// ----------------------------------------------------------------------------
module node_command_byte_parser_top #(
  parameter int NOTE_DEPTH = ncbp_pkg::NOTE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ncbp_pkg::NODE_W-1:0]  cfg_node_id,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ncbp_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_reply_valid,
  output logic [1:0]                   out_reply_code,
  output logic                         out_entry_valid,
  output logic [ncbp_pkg::INDEX_W-1:0] out_entry_index,
  output logic [ncbp_pkg::BYTE_W-1:0]  out_entry_note,
  output logic [ncbp_pkg::DUR_W-1:0]   out_entry_duration,
  output logic                         out_playing,
  output logic                         out_restart_playback,
  output logic                         out_clear_sync_wait,
  output logic                         out_data_ready
);

  logic              accept;
  logic              can_push;
  ncbp_pkg::result_t step_res;
  ncbp_pkg::result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_push;
  assign accept    = in_valid && can_push;

  // byte parser
  ncbp_parser #(
    .NOTE_DEPTH (NOTE_DEPTH)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid),
    .cfg_node_id (cfg_node_id),
    .byte_we     (accept),
    .rx_byte     (in_rx_byte),
    .result      (step_res)
  );

  // result buffer
  ncbp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (step_res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  // result fields
  assign out_reply_valid      = out_res.reply_valid;
  assign out_reply_code       = out_res.reply_code;
  assign out_entry_valid      = out_res.entry_valid;
  assign out_entry_index      = out_res.entry_index;
  assign out_entry_note       = out_res.entry_note;
  assign out_entry_duration   = out_res.entry_duration;
  assign out_playing          = out_res.playing;
  assign out_restart_playback = out_res.restart_playback;
  assign out_clear_sync_wait  = out_res.clear_sync_wait;
  assign out_data_ready       = out_res.data_ready;

endmodule
